### rtl/core/qmn_pkg.sv
// ----------------------------------------------------------------------------
// Quaternion multiply/normalize package
// Shared widths, codes, payload types and saturation helpers.
// ----------------------------------------------------------------------------
package qmn_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COMP_WIDTH = 32;

    localparam int FW   = 32;                      // port field width
    localparam int CW   = COMP_WIDTH;              // component width
    localparam int OW   = CW + 1;                  // operand sum width
    localparam int PW   = 2 * OW;                  // full product width
    localparam int QW   = PW - FRAC_BITS;          // floored product width
    localparam int VW   = QW + 3;                  // merged result width
    localparam int SW   = 2 * CW + 2 - FRAC_BITS;  // sum of squares width
    localparam int RW   = CW + 1;                  // square root width
    localparam int NW   = 2 * RW;                  // radicand width
    localparam int RMW  = RW + 2;                  // root remainder width
    localparam int IW   = 2 * FRAC_BITS + 1;       // reciprocal width
    localparam int HALF = (IW + 1) / 2;            // low slice of reciprocal
    localparam int HW   = IW - HALF;               // high slice of reciprocal
    localparam int PLW  = CW + HALF + 1;
    localparam int PHW  = CW + HW + 1;
    localparam int PRW  = CW + IW + 1;
    localparam int SCW  = PRW - FRAC_BITS;         // scaled component width
    localparam int XW   = (VW > SCW) ? VW : SCW;   // pre-saturation width

    localparam logic CMD_MUL  = 1'b0;
    localparam logic CMD_NORM = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    typedef struct packed {
        logic                 cmd;
        logic signed [FW-1:0] a_w;
        logic signed [FW-1:0] a_x;
        logic signed [FW-1:0] a_y;
        logic signed [FW-1:0] a_z;
        logic signed [FW-1:0] b_w;
        logic signed [FW-1:0] b_x;
        logic signed [FW-1:0] b_y;
        logic signed [FW-1:0] b_z;
    } t_in;

    typedef struct packed {
        logic signed [FW-1:0] r_w;
        logic signed [FW-1:0] r_x;
        logic signed [FW-1:0] r_y;
        logic signed [FW-1:0] r_z;
        logic [1:0]           status;
    } t_out;

    // Operands of one lane: two products (u +/- v) * (u +/- v).
    typedef struct packed {
        logic signed [CW-1:0] ua;
        logic signed [CW-1:0] va;
        logic                 sa;
        logic signed [CW-1:0] ub;
        logic signed [CW-1:0] vb;
        logic                 sb;
        logic signed [CW-1:0] uc;
        logic signed [CW-1:0] vc;
        logic                 sc;
        logic signed [CW-1:0] ud;
        logic signed [CW-1:0] vd;
        logic                 sd;
        logic signed [CW-1:0] keep;
    } t_lane_in;

    // Per-item context carried alongside the root and reciprocal pipeline.
    typedef struct packed {
        logic                 cmd;
        logic                 zero;
        logic [3:0][VW-1:0]   v;
    } t_ctx;

    function automatic logic signed [CW-1:0] f_sat(input logic signed [XW-1:0] x);
        logic signed [CW-1:0] res;
        if (x > XW'(CMAX)) begin
            res = CMAX;
        end else if (x < XW'(CMIN)) begin
            res = CMIN;
        end else begin
            res = x[CW-1:0];
        end
        return res;
    endfunction

    function automatic logic f_over(input logic signed [XW-1:0] x);
        return (x > XW'(CMAX)) || (x < XW'(CMIN));
    endfunction

endpackage

### rtl/core/qmn_lane.sv
// ----------------------------------------------------------------------------
// Quaternion product lane
// Forms four operand sums, then two full-width signed products, floored.
// ----------------------------------------------------------------------------
module qmn_lane import qmn_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  t_lane_in             i_lane,
    output logic signed [QW-1:0] o_p0,
    output logic signed [QW-1:0] o_p1,
    output logic signed [CW-1:0] o_keep
);

    logic signed [OW-1:0] r_opa, r_opb, r_opc, r_opd;
    logic signed [CW-1:0] r_keep_a, r_keep_b;
    logic signed [PW-1:0] r_prod0, r_prod1;
    logic signed [OW-1:0] n_opa, n_opb, n_opc, n_opd;

    always_comb begin
        n_opa = i_lane.sa ? OW'(i_lane.ua) - OW'(i_lane.va) : OW'(i_lane.ua) + OW'(i_lane.va);
        n_opb = i_lane.sb ? OW'(i_lane.ub) - OW'(i_lane.vb) : OW'(i_lane.ub) + OW'(i_lane.vb);
        n_opc = i_lane.sc ? OW'(i_lane.uc) - OW'(i_lane.vc) : OW'(i_lane.uc) + OW'(i_lane.vc);
        n_opd = i_lane.sd ? OW'(i_lane.ud) - OW'(i_lane.vd) : OW'(i_lane.ud) + OW'(i_lane.vd);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_opa    <= n_opa;
            r_opb    <= n_opb;
            r_opc    <= n_opc;
            r_opd    <= n_opd;
            r_keep_a <= i_lane.keep;
            r_prod0  <= r_opa * r_opb;
            r_prod1  <= r_opc * r_opd;
            r_keep_b <= r_keep_a;
        end
    end

    // Dropping the fraction bits of a signed product rounds toward minus infinity.
    assign o_p0   = r_prod0[PW-1:FRAC_BITS];
    assign o_p1   = r_prod1[PW-1:FRAC_BITS];
    assign o_keep = r_keep_b;

endmodule

### rtl/core/qmn_merge.sv
// ----------------------------------------------------------------------------
// Quaternion lane merge
// Combines the eight lane products into w, x, y, z, or the four squares
// into the sum of squares.
// ----------------------------------------------------------------------------
module qmn_merge import qmn_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic                i_cmd,
    input  logic [3:0][QW-1:0]  i_p0,
    input  logic [3:0][QW-1:0]  i_p1,
    input  logic [3:0][CW-1:0]  i_keep,
    output logic                o_valid,
    output t_ctx                o_ctx,
    output logic [SW-1:0]       o_s
);

    logic [2:0] r_vld;

    logic                  r1_cmd;
    logic [3:0][QW-1:0]    r1_p;
    logic [3:0][CW-1:0]    r1_k;
    logic signed [QW:0]    r1_a56, r1_d56, r1_a78, r1_d78;

    logic                  r2_cmd;
    logic [3:0][QW-1:0]    r2_p;
    logic [3:0][CW-1:0]    r2_k;
    logic signed [QW+1:0]  r2_sw, r2_sx, r2_sy, r2_sz;

    t_ctx                  r_ctx;
    logic [SW-1:0]         r_s;
    t_ctx                  n_ctx;
    logic [SW-1:0]         n_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    // In normalize every lane's second product is a square, so x's sum is s.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_cmd <= i_cmd;
            r1_p   <= i_p0;
            r1_k   <= i_keep;
            r1_a56 <= (QW+1)'($signed(i_p1[0])) + (QW+1)'($signed(i_p1[1]));
            r1_d56 <= (QW+1)'($signed(i_p1[0])) - (QW+1)'($signed(i_p1[1]));
            r1_a78 <= (QW+1)'($signed(i_p1[2])) + (QW+1)'($signed(i_p1[3]));
            r1_d78 <= (QW+1)'($signed(i_p1[2])) - (QW+1)'($signed(i_p1[3]));

            r2_cmd <= r1_cmd;
            r2_p   <= r1_p;
            r2_k   <= r1_k;
            r2_sw  <= (QW+2)'(r1_a78) - (QW+2)'(r1_a56);
            r2_sx  <= (QW+2)'(r1_a56) + (QW+2)'(r1_a78);
            r2_sy  <= (QW+2)'(r1_d56) + (QW+2)'(r1_d78);
            r2_sz  <= (QW+2)'(r1_d56) - (QW+2)'(r1_d78);

            r_ctx  <= n_ctx;
            r_s    <= n_s;
        end
    end

    always_comb begin
        n_s      = r2_sx[SW-1:0];
        n_ctx    = '0;
        n_ctx.cmd = r2_cmd;
        if (r2_cmd == CMD_MUL) begin
            n_ctx.v[0] = VW'($signed(r2_p[1])) + VW'(r2_sw >>> 1);
            n_ctx.v[1] = VW'($signed(r2_p[0])) - VW'(r2_sx >>> 1);
            n_ctx.v[2] = VW'($signed(r2_p[2])) + VW'(r2_sy >>> 1);
            n_ctx.v[3] = VW'($signed(r2_p[3])) + VW'(r2_sz >>> 1);
        end else begin
            n_ctx.zero = (n_s == '0);
            for (int i = 0; i < 4; i++) begin
                n_ctx.v[i] = VW'($signed(r2_k[i]));
            end
        end
    end

    assign o_valid = r_vld[2];
    assign o_ctx   = r_ctx;
    assign o_s     = r_s;

endmodule

### rtl/core/qmn_rootinv.sv
// ----------------------------------------------------------------------------
// Square root and reciprocal pipeline
// One root bit per stage, then one quotient bit per stage of 2^(2F) / root.
// ----------------------------------------------------------------------------
module qmn_rootinv import qmn_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  t_ctx           i_ctx,
    input  logic [SW-1:0]  i_s,
    output logic           o_valid,
    output t_ctx           o_ctx,
    output logic [IW-1:0]  o_inv
);

    logic                 r_sq_vld  [RW];
    t_ctx                 r_sq_ctx  [RW];
    logic [RW-1:0]        r_sq_root [RW];
    logic [RMW-1:0]       r_sq_rem  [RW];
    logic [NW-1:0]        r_sq_n    [RW];

    logic                 r_dv_vld  [IW];
    t_ctx                 r_dv_ctx  [IW];
    logic [RW-1:0]        r_dv_root [IW];
    logic [RW-1:0]        r_dv_rem  [IW];
    logic [IW-1:0]        r_dv_q    [IW];

    for (genvar k = 0; k < RW; k++) begin : g_sq
        logic           vld_in;
        t_ctx           ctx_in;
        logic [RW-1:0]  root_in;
        logic [RMW-1:0] rem_in;
        logic [NW-1:0]  n_in;
        logic [RMW-1:0] rem_sh;
        logic [RMW-1:0] trial;

        if (k == 0) begin : g_first
            assign vld_in  = i_valid;
            assign ctx_in  = i_ctx;
            assign root_in = '0;
            assign rem_in  = '0;
            assign n_in    = {i_s, {FRAC_BITS{1'b0}}};
        end else begin : g_next
            assign vld_in  = r_sq_vld[k-1];
            assign ctx_in  = r_sq_ctx[k-1];
            assign root_in = r_sq_root[k-1];
            assign rem_in  = r_sq_rem[k-1];
            assign n_in    = r_sq_n[k-1];
        end

        assign rem_sh = {rem_in[RMW-3:0], n_in[NW-1 -: 2]};
        assign trial  = {root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_sq_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq_ctx[k] <= ctx_in;
                r_sq_n[k]   <= n_in << 2;
                if (rem_sh >= trial) begin
                    r_sq_rem[k]  <= rem_sh - trial;
                    r_sq_root[k] <= {root_in[RW-2:0], 1'b1};
                end else begin
                    r_sq_rem[k]  <= rem_sh;
                    r_sq_root[k] <= {root_in[RW-2:0], 1'b0};
                end
            end
        end
    end

    for (genvar j = 0; j < IW; j++) begin : g_dv
        logic           vld_in;
        t_ctx           ctx_in;
        logic [RW-1:0]  root_in;
        logic [RW-1:0]  rem_in;
        logic [IW-1:0]  q_in;
        logic [RW:0]    trial;

        if (j == 0) begin : g_first
            assign vld_in  = r_sq_vld[RW-1];
            assign ctx_in  = r_sq_ctx[RW-1];
            assign root_in = r_sq_root[RW-1];
            assign rem_in  = '0;
            assign q_in    = '0;
            assign trial   = {rem_in, 1'b1};   // the dividend's only set bit
        end else begin : g_next
            assign vld_in  = r_dv_vld[j-1];
            assign ctx_in  = r_dv_ctx[j-1];
            assign root_in = r_dv_root[j-1];
            assign rem_in  = r_dv_rem[j-1];
            assign q_in    = r_dv_q[j-1];
            assign trial   = {rem_in, 1'b0};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_dv_vld[j] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv_ctx[j]  <= ctx_in;
                r_dv_root[j] <= root_in;
                if (trial >= {1'b0, root_in}) begin
                    r_dv_rem[j] <= RW'(trial - {1'b0, root_in});
                    r_dv_q[j]   <= {q_in[IW-2:0], 1'b1};
                end else begin
                    r_dv_rem[j] <= RW'(trial);
                    r_dv_q[j]   <= {q_in[IW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_dv_vld[IW-1];
    assign o_ctx   = r_dv_ctx[IW-1];
    assign o_inv   = r_dv_q[IW-1];

endmodule

### rtl/core/qmn_scale.sv
// ----------------------------------------------------------------------------
// Normalize scaling lane
// Multiplies one component by the reciprocal in two slices, floors, and
// selects between the product result, the scaled component and zero.
// ----------------------------------------------------------------------------
module qmn_scale import qmn_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic                 i_cmd,
    input  logic                 i_zero,
    input  logic [VW-1:0]        i_v,
    input  logic [IW-1:0]        i_inv,
    output logic signed [XW-1:0] o_val
);

    logic signed [CW-1:0]   comp;
    logic signed [HALF:0]   inv_lo;
    logic signed [HW:0]     inv_hi;
    logic signed [PLW-1:0]  r_pl;
    logic signed [PHW-1:0]  r_ph;
    logic                   r_cmd, r_zero;
    logic signed [VW-1:0]   r_v;
    logic signed [PRW-1:0]  prod;
    logic signed [SCW-1:0]  scaled;
    logic signed [XW-1:0]   r_val;

    assign comp   = i_v[CW-1:0];
    assign inv_lo = {1'b0, i_inv[HALF-1:0]};
    assign inv_hi = {1'b0, i_inv[IW-1:HALF]};

    assign prod   = (PRW'(r_ph) <<< HALF) + PRW'(r_pl);
    assign scaled = prod[PRW-1:FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pl   <= comp * inv_lo;
            r_ph   <= comp * inv_hi;
            r_cmd  <= i_cmd;
            r_zero <= i_zero;
            r_v    <= i_v;
            if (r_zero) begin
                r_val <= '0;
            end else if (r_cmd == CMD_MUL) begin
                r_val <= XW'(r_v);
            end else begin
                r_val <= XW'(scaled);
            end
        end
    end

    assign o_val = r_val;

endmodule

### rtl/core/quaternion_multiply_normalize.sv
// ----------------------------------------------------------------------------
// Quaternion multiply / normalize
// Hamilton product of two fixed-point quaternions, or normalization of one.
// ----------------------------------------------------------------------------
// The block takes one item per clock while the output is not stalled and
// returns exactly one result item per item, in order. The pipeline holds two
// lane stages, three merge stages, COMP_WIDTH+1 square-root stages,
// 2*FRAC_BITS+1 reciprocal stages, two scaling stages and the output
// register. Multiply items travel the same pipeline as normalize items so
// that order is kept. Four lanes each form two of the eight products (for
// normalize, the square of one component), the merge stages combine them, the
// root and reciprocal are produced one bit per stage, and four scaling lanes
// apply the reciprocal. The whole pipeline advances whenever the output
// register is empty or its item is being taken, so the sustained rate is one
// item per cycle as long as the consumer keeps up. Status reports 2 for a
// zero-length normalize (sum of floored squares zero), 1 when any component
// saturated, and 0 otherwise.
// ----------------------------------------------------------------------------
module quaternion_multiply_normalize import qmn_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_item,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_item
);

    logic                  en;
    logic signed [CW-1:0]  aw, ax, ay, az, bw, bx, by, bz;
    t_lane_in              lane_in [4];
    logic [3:0][QW-1:0]    lane_p0, lane_p1;
    logic [3:0][CW-1:0]    lane_keep;

    logic [1:0]            r_lane_vld;
    logic [1:0]            r_lane_cmd;

    logic                  mrg_vld;
    t_ctx                  mrg_ctx;
    logic [SW-1:0]         mrg_s;

    logic                  ri_vld;
    t_ctx                  ri_ctx;
    logic [IW-1:0]         ri_inv;

    logic [1:0]            r_sc_vld;
    logic [1:0]            r_sc_zero;
    logic signed [XW-1:0]  sc_val [4];

    logic                  r_out_vld;
    t_out                  r_out;
    t_out                  n_out;

    // The pipeline moves as one; the output register is the only place an item waits.
    assign en      = !r_out_vld || i_ready;
    assign o_ready = en;

    assign aw = CW'(i_item.a_w);
    assign ax = CW'(i_item.a_x);
    assign ay = CW'(i_item.a_y);
    assign az = CW'(i_item.a_z);
    assign bw = CW'(i_item.b_w);
    assign bx = CW'(i_item.b_x);
    assign by = CW'(i_item.b_y);
    assign bz = CW'(i_item.b_z);

    // Lane k forms P(k+1) as its first product and P(k+5) as its second.
    always_comb begin
        if (i_item.cmd == CMD_MUL) begin
            lane_in[0] = '{ua: aw, va: ax, sa: 1'b0, ub: bw, vb: bx, sb: 1'b0,
                           uc: ax, vc: az, sc: 1'b0, ud: bx, vd: by, sd: 1'b0, keep: aw};
            lane_in[1] = '{ua: az, va: ay, sa: 1'b1, ub: by, vb: bz, sb: 1'b1,
                           uc: ax, vc: az, sc: 1'b1, ud: bx, vd: by, sd: 1'b1, keep: ax};
            lane_in[2] = '{ua: aw, va: ax, sa: 1'b1, ub: by, vb: bz, sb: 1'b0,
                           uc: aw, vc: ay, sc: 1'b0, ud: bw, vd: bz, sd: 1'b1, keep: ay};
            lane_in[3] = '{ua: ay, va: az, sa: 1'b0, ub: bw, vb: bx, sb: 1'b1,
                           uc: aw, vc: ay, sc: 1'b1, ud: bw, vd: bz, sd: 1'b0, keep: az};
        end else begin
            // Normalize: both products of a lane are the square of its component.
            lane_in[0] = '{ua: aw, va: '0, sa: 1'b0, ub: aw, vb: '0, sb: 1'b0,
                           uc: aw, vc: '0, sc: 1'b0, ud: aw, vd: '0, sd: 1'b0, keep: aw};
            lane_in[1] = '{ua: ax, va: '0, sa: 1'b0, ub: ax, vb: '0, sb: 1'b0,
                           uc: ax, vc: '0, sc: 1'b0, ud: ax, vd: '0, sd: 1'b0, keep: ax};
            lane_in[2] = '{ua: ay, va: '0, sa: 1'b0, ub: ay, vb: '0, sb: 1'b0,
                           uc: ay, vc: '0, sc: 1'b0, ud: ay, vd: '0, sd: 1'b0, keep: ay};
            lane_in[3] = '{ua: az, va: '0, sa: 1'b0, ub: az, vb: '0, sb: 1'b0,
                           uc: az, vc: '0, sc: 1'b0, ud: az, vd: '0, sd: 1'b0, keep: az};
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_lane
        qmn_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_lane (lane_in[g]),
            .o_p0   (lane_p0[g]),
            .o_p1   (lane_p1[g]),
            .o_keep (lane_keep[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane_vld <= '0;
        end else if (en) begin
            r_lane_vld <= {r_lane_vld[0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lane_cmd <= {r_lane_cmd[0], i_item.cmd};
        end
    end

    qmn_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_lane_vld[1]),
        .i_cmd   (r_lane_cmd[1]),
        .i_p0    (lane_p0),
        .i_p1    (lane_p1),
        .i_keep  (lane_keep),
        .o_valid (mrg_vld),
        .o_ctx   (mrg_ctx),
        .o_s     (mrg_s)
    );

    qmn_rootinv u_rootinv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (mrg_vld),
        .i_ctx   (mrg_ctx),
        .i_s     (mrg_s),
        .o_valid (ri_vld),
        .o_ctx   (ri_ctx),
        .o_inv   (ri_inv)
    );

    for (genvar g = 0; g < 4; g++) begin : g_scale
        qmn_scale u_scale (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_cmd  (ri_ctx.cmd),
            .i_zero (ri_ctx.zero),
            .i_v    (ri_ctx.v[g]),
            .i_inv  (ri_inv),
            .o_val  (sc_val[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc_vld <= '0;
        end else if (en) begin
            r_sc_vld <= {r_sc_vld[0], ri_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sc_zero <= {r_sc_zero[0], ri_ctx.zero};
        end
    end

    // Saturate to the component range and sign-extend to the port width.
    always_comb begin
        n_out.r_w = FW'(f_sat(sc_val[0]));
        n_out.r_x = FW'(f_sat(sc_val[1]));
        n_out.r_y = FW'(f_sat(sc_val[2]));
        n_out.r_z = FW'(f_sat(sc_val[3]));
        if (r_sc_zero[1]) begin
            n_out.status = ST_ZERO;
        end else if (f_over(sc_val[0]) || f_over(sc_val[1]) ||
                     f_over(sc_val[2]) || f_over(sc_val[3])) begin
            n_out.status = ST_SAT;
        end else begin
            n_out.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_sc_vld[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_item  = r_out;

    // A zero-length normalize returns an all-zero quaternion.
    a_zero_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.status == ST_ZERO) |->
        (o_item.r_w == '0 && o_item.r_x == '0 && o_item.r_y == '0 && o_item.r_z == '0))
        else $error("zero-length result with nonzero component");

    // An accepted item enters the first lane stage.
    a_enter : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_lane_vld[0])
        else $error("accepted item lost at lane entry");

    // Input is refused only while a result waits at the output.
    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("pipeline stalled without a waiting result");

endmodule
